// File: hw/rtl/erd_pkg.sv
// ----------------------------------------------------------------------------
// Escape RLE run decoder package
// Shared types and constants for the run decoder and its result queue.
// ----------------------------------------------------------------------------
`default_nettype none

package erd_pkg;

	localparam logic [7:0] ESC_BYTE = 8'hED;
	localparam logic [8:0] FULL_RUN = 9'd256;

	localparam logic [15:0] DEST_BASE_RST = 16'h4000;
	localparam logic [16:0] DEST_END_RST  = 17'h10000;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int OUT_TDATA_W = 40;

	// Configuration register indices.
	typedef enum logic [1:0] {
		REG_COMPRESSED_MODE = 2'd0,
		REG_DEST_BASE       = 2'd1,
		REG_DEST_END        = 2'd2
	} reg_idx_t;

	// Decode phases.
	typedef enum logic [1:0] {
		PH_PLAIN = 2'd0,
		PH_ONE_ED = 2'd1,
		PH_TWO_ED = 2'd2,
		PH_COUNT = 2'd3
	} phase_t;

	typedef struct packed {
		logic [15:0] write_address;
		logic [7:0]  fill_value;
		logic [8:0]  run_length;
		logic        stream_end;
	} res_t;

	// Results produced by one accepted byte: up to two words.
	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} push_t;

endpackage

`default_nettype wire

// File: hw/rtl/escape_rle_run_decoder_core.sv
// ----------------------------------------------------------------------------
// Escape RLE run decoder core
// Turns a snapshot RAM byte stream into memory-fill commands.
// ----------------------------------------------------------------------------
// The core takes one byte per cycle on the s_ stream and emits fill words
// (address, value, length) on the m_ stream. A byte is decoded in the cycle it
// is accepted by the decode stage and its words enter a four-word queue, so
// the input keeps taking one byte per cycle while the output drains at one
// word per cycle while m_tready is high; a lone ED makes two words, and the
// input pauses only when the queue holds more than two. The tlast byte closes
// the stream: its last word carries tlast, and an end marker of length zero
// is sent if it would otherwise make none. Configuration writes are taken at
// once, and are meant for times when no stream is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module escape_rle_run_decoder_core
	import erd_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [7:0]             s_tdata,   // [7:0] data_byte
	input  wire logic                   s_tlast,   // last_byte
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_TDATA_W-1:0]      m_tdata,   // [15:0] write_address, [23:16] fill_value,
	                                               // [32:24] run_length, [39:33] zero
	output logic                        m_tlast,   // stream_end
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [1:0]             cfg_index,
	input  wire logic [16:0]            cfg_data
);

	push_t push;
	res_t  head;
	logic  room;
	logic  accept;

	assign s_tready  = room;
	assign accept    = s_tvalid && room;
	assign cfg_ready = 1'b1;

	erd_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (s_tdata),
		.last_byte (s_tlast),
		.cfg_write (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push)
	);

	erd_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (head)
	);

	assign m_tdata = {7'd0, head.run_length, head.fill_value, head.write_address};
	assign m_tlast = head.stream_end;

endmodule

`default_nettype wire

// File: hw/rtl/erd_decode.sv
// ----------------------------------------------------------------------------
// Escape RLE run decoder: decode stage
// Holds the configuration and the decode state, and turns each accepted byte
// into zero, one or two fill commands with clipping at the destination limit.
// ----------------------------------------------------------------------------
`default_nettype none

module erd_decode
	import erd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        accept,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	input  wire logic        cfg_write,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [16:0] cfg_data,
	output push_t            push
);

	logic        compressed_mode_q;
	logic [15:0] dest_base_q;
	logic [16:0] dest_end_q;
	phase_t      phase_q;
	logic [7:0]  held_count_q;
	logic [16:0] write_pointer_q;

	phase_t      phase_n;
	logic [7:0]  held_count_n;
	logic        req_a;
	logic        req_b;
	logic [7:0]  val_a;
	logic [7:0]  val_b;
	logic [8:0]  len_a;
	logic [16:0] avail;
	logic [8:0]  clip_a;
	logic [16:0] avail_b;
	logic        v_a;
	logic        v_b;
	logic [16:0] wp_b;
	logic [16:0] wp_n;
	res_t        res_a;
	res_t        res_b;
	res_t        res_mark;

	always_comb begin
		phase_n      = phase_q;
		held_count_n = held_count_q;
		req_a        = 1'b0;
		req_b        = 1'b0;
		val_a        = data_byte;
		val_b        = data_byte;
		len_a        = 9'd1;
		if (!compressed_mode_q) begin
			phase_n = PH_PLAIN;
			req_a   = 1'b1;
		end else begin
			case (phase_q)
				PH_PLAIN: begin
					if (data_byte == ESC_BYTE) begin
						phase_n = PH_ONE_ED;
					end else begin
						req_a = 1'b1;
					end
				end
				PH_ONE_ED: begin
					if (data_byte == ESC_BYTE) begin
						phase_n = PH_TWO_ED;
					end else begin
						req_a   = 1'b1;
						val_a   = ESC_BYTE;
						req_b   = 1'b1;
						phase_n = PH_PLAIN;
					end
				end
				PH_TWO_ED: begin
					held_count_n = data_byte;
					phase_n      = PH_COUNT;
				end
				PH_COUNT: begin
					req_a   = 1'b1;
					len_a   = (held_count_q == 8'd0) ? FULL_RUN : {1'b0, held_count_q};
					phase_n = PH_PLAIN;
				end
				default: begin
					phase_n = PH_PLAIN;
				end
			endcase
		end
		// A single ED left pending at the end of the stream is flushed as a literal.
		if (last_byte && phase_n == PH_ONE_ED) begin
			req_b = 1'b1;
			val_b = ESC_BYTE;
		end
	end

	// Clip each run to the space left below the destination limit.
	always_comb begin
		avail   = (dest_end_q > write_pointer_q) ? (dest_end_q - write_pointer_q) : 17'd0;
		clip_a  = req_a ? ((17'(len_a) > avail) ? avail[8:0] : len_a) : 9'd0;
		v_a     = clip_a != 9'd0;
		wp_b    = write_pointer_q + 17'(clip_a);
		avail_b = avail - 17'(clip_a);
		v_b     = req_b && (avail_b != 17'd0);
		wp_n    = wp_b + (v_b ? 17'd1 : 17'd0);
	end

	always_comb begin
		res_a.write_address = write_pointer_q[15:0];
		res_a.fill_value    = val_a;
		res_a.run_length    = clip_a;
		res_a.stream_end    = last_byte && !v_b;
		res_b.write_address = wp_b[15:0];
		res_b.fill_value    = val_b;
		res_b.run_length    = 9'd1;
		res_b.stream_end    = last_byte;
		res_mark.write_address = write_pointer_q[15:0];
		res_mark.fill_value    = 8'd0;
		res_mark.run_length    = 9'd0;
		res_mark.stream_end    = 1'b1;

		push.r1 = res_b;
		if (v_a) begin
			push.r0 = res_a;
			push.n  = v_b ? 2'd2 : 2'd1;
		end else if (v_b) begin
			push.r0 = res_b;
			push.n  = 2'd1;
		end else begin
			push.r0 = res_mark;
			push.n  = last_byte ? 2'd1 : 2'd0;
		end
		if (!accept) begin
			push.n = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			compressed_mode_q <= 1'b1;
			dest_base_q       <= DEST_BASE_RST;
			dest_end_q        <= DEST_END_RST;
			phase_q           <= PH_PLAIN;
			held_count_q      <= 8'd0;
			write_pointer_q   <= {1'b0, DEST_BASE_RST};
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_COMPRESSED_MODE: compressed_mode_q <= cfg_data[0];
					REG_DEST_BASE: begin
						dest_base_q     <= cfg_data[15:0];
						write_pointer_q <= {1'b0, cfg_data[15:0]};
					end
					REG_DEST_END: dest_end_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (accept) begin
				if (last_byte) begin
					phase_q         <= PH_PLAIN;
					held_count_q    <= 8'd0;
					write_pointer_q <= {1'b0, dest_base_q};
				end else begin
					phase_q         <= phase_n;
					held_count_q    <= held_count_n;
					write_pointer_q <= wp_n;
				end
			end
		end
	end

	// The final byte of a stream always yields at least one word.
	a_last_yields: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_byte) |-> (push.n != 2'd0))
		else $error("final byte produced no result");

	// A stream closes with the decoder back in its plain phase.
	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_byte) |=> (phase_q == PH_PLAIN && held_count_q == 8'd0))
		else $error("decode state not cleared after stream end");

	// A second word only follows a lone ED.
	a_two_words: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n == 2'd2) |-> (push.r1.run_length == 9'd1 && push.r0.run_length == 9'd1))
		else $error("unexpected pair of results");

endmodule

`default_nettype wire

// File: hw/rtl/erd_out_queue.sv
// ----------------------------------------------------------------------------
// Escape RLE run decoder: result queue
// Small queue that takes up to two result words a cycle and delivers one while out_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module erd_out_queue
	import erd_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire push_t push,
	output logic       room,
	output logic       out_valid,
	input  wire logic  out_ready,
	output res_t       out_res
);

	res_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] count_q;
	logic              pop;
	logic [QPTR_W-1:0] wr_1;

	assign out_valid = count_q != '0;
	assign out_res   = mem_q[rd_q];
	assign pop       = out_valid && out_ready;
	// Room is kept for the worst case of two words from the next byte.
	assign room      = count_q <= QCNT_W'(QUEUE_DEPTH - 2);
	assign wr_1      = wr_q + QPTR_W'(1);

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + QPTR_W'(push.n);
			count_q <= count_q + QCNT_W'(push.n) - (pop ? QCNT_W'(1) : QCNT_W'(0));
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("result queue overflow");

	a_push_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n != 2'd0) |-> room)
		else $error("words pushed without room");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> (count_q == $past(count_q) + QCNT_W'($past(push.n))
			- ($past(pop) ? QCNT_W'(1) : QCNT_W'(0))))
		else $error("queue fill count out of step");

endmodule

`default_nettype wire
